FILE: hw/rtl/bha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bha_pkg;

  // Default geometry of the heap.
  localparam int HEAP_LOG_DEF         = 16;
  localparam int MIN_BLOCK_LOG_DEF    = 4;
  localparam int INITIAL_ROOT_LOG_DEF = 4;

  // Fixed field widths.
  localparam int LOG_W = 5;
  localparam int REQ_W = 17;
  localparam int CNT_W = 13;
  localparam int TOT_W = 17;
  localparam int NEED_W = 18;

  // Header that sits in front of every payload, and request rounding.
  localparam logic [31:0] HDR_BYTES = 32'd12;
  localparam logic [NEED_W-1:0] ROUND_ADD = NEED_W'(3);

  // Command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Heap state codes.
  localparam logic [1:0] HS_UNINIT = 2'd0;
  localparam logic [1:0] HS_NORMAL = 2'd1;
  localparam logic [1:0] HS_EMPTY  = 2'd2;

  // Per-field write enables of the header memory.
  typedef struct packed {
    logic size;
    logic nxt;
    logic prv;
    logic free;
    logic req;
  } mem_we_t;

  // One result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      ptr;
    logic [LOG_W-1:0] root;
    logic [CNT_W-1:0] count;
    logic [TOT_W-1:0] req_total;
    logic [TOT_W-1:0] blk_total;
  } res_t;

  // Two to the power s, wide enough for any five-bit exponent.
  function automatic logic [32:0] pow2(input logic [LOG_W-1:0] s);
    pow2 = 33'(1) << s;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bha_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel.
interface bha_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] request_bytes;
  logic [31:0] release_pointer;
  modport source (output valid, cmd, request_bytes, release_pointer, input ready);
  modport sink (input valid, cmd, request_bytes, release_pointer, output ready);
endinterface

// Result channel.
interface bha_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] payload_pointer;
  logic [4:0]  root_size_log;
  logic [12:0] live_allocations;
  logic [16:0] live_requested_bytes;
  logic [16:0] live_block_bytes;
  modport source (output valid, status, payload_pointer, root_size_log, live_allocations,
                  live_requested_bytes, live_block_bytes, input ready);
  modport sink (input valid, status, payload_pointer, root_size_log, live_allocations,
                live_requested_bytes, live_block_bytes, output ready);
endinterface

// Configuration write channel.
interface bha_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] heap_base;
  modport source (output valid, heap_base, input ready);
  modport sink (input valid, heap_base, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bha_cell_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module bha_cell_mem
  import bha_pkg::*;
#(
  parameter int CW = HEAP_LOG_DEF - MIN_BLOCK_LOG_DEF
) (
  input  wire logic             clk,
  input  wire logic [CW-1:0]    addr,
  input  wire mem_we_t          we,
  input  wire logic [LOG_W-1:0] w_size,
  input  wire logic [CW-1:0]    w_next,
  input  wire logic [CW-1:0]    w_prev,
  input  wire logic             w_free,
  input  wire logic [REQ_W-1:0] w_req,
  output logic [LOG_W-1:0]      rd_size,
  output logic [CW-1:0]         rd_next,
  output logic [CW-1:0]         rd_prev,
  output logic                  rd_free,
  output logic [REQ_W-1:0]      rd_req
);

  localparam int DEPTH = 1 << CW;

  logic [LOG_W-1:0] size_mem [DEPTH];
  logic [CW-1:0]    next_mem [DEPTH];
  logic [CW-1:0]    prev_mem [DEPTH];
  logic             free_mem [DEPTH];
  logic [REQ_W-1:0] req_mem  [DEPTH];

  // Field writes share one address; each field has its own enable.
  always_ff @(posedge clk) begin
    if (we.size) size_mem[addr] <= w_size;
    if (we.nxt)  next_mem[addr] <= w_next;
    if (we.prv)  prev_mem[addr] <= w_prev;
    if (we.free) free_mem[addr] <= w_free;
    if (we.req)  req_mem[addr]  <= w_req;
  end

  // Registered read of the whole header entry.
  always_ff @(posedge clk) begin
    rd_size <= size_mem[addr];
    rd_next <= next_mem[addr];
    rd_prev <= prev_mem[addr];
    rd_free <= free_mem[addr];
    rd_req  <= req_mem[addr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bha_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module bha_seq
  import bha_pkg::*;
#(
  parameter int HEAP_LOG         = HEAP_LOG_DEF,
  parameter int MIN_BLOCK_LOG    = MIN_BLOCK_LOG_DEF,
  parameter int INITIAL_ROOT_LOG = INITIAL_ROOT_LOG_DEF,
  parameter int CW               = HEAP_LOG - MIN_BLOCK_LOG
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             cmd,
  input  wire logic [15:0]      request_bytes,
  input  wire logic [31:0]      release_pointer,
  input  wire logic [31:0]      heap_base,
  output logic                  idle,
  output logic                  res_valid,
  input  wire logic             res_take,
  output res_t                  res,
  output logic [CW-1:0]         mem_addr,
  output mem_we_t               mem_we,
  output logic [LOG_W-1:0]      w_size,
  output logic [CW-1:0]         w_next,
  output logic [CW-1:0]         w_prev,
  output logic                  w_free,
  output logic [REQ_W-1:0]      w_req,
  input  wire logic [LOG_W-1:0] rd_size,
  input  wire logic [CW-1:0]    rd_next,
  input  wire logic [CW-1:0]    rd_prev,
  input  wire logic             rd_free,
  input  wire logic [REQ_W-1:0] rd_req
);

  localparam int ROOT_LO = (INITIAL_ROOT_LOG < MIN_BLOCK_LOG) ? MIN_BLOCK_LOG
                                                              : INITIAL_ROOT_LOG;
  localparam int ROOT_INIT = (ROOT_LO > HEAP_LOG) ? HEAP_LOG : ROOT_LO;
  localparam logic [LOG_W-1:0] HEAP_L = LOG_W'(HEAP_LOG);
  localparam logic [LOG_W-1:0] MIN_L  = LOG_W'(MIN_BLOCK_LOG);
  localparam logic [CW:0]      STEP_MAX = {1'b1, {CW{1'b0}}};

  // Two to the power s, cut to a cell index.
  function automatic logic [CW-1:0] cell_pow(input logic [LOG_W-1:0] s);
    logic [32:0] p;
    p = pow2(s);
    return p[CW-1:0];
  endfunction

  typedef enum logic [25:0] {
    S_IDLE   = 26'd1 << 0,
    S_INIT   = 26'd1 << 1,
    S_ACHK   = 26'd1 << 2,
    S_GCALC  = 26'd1 << 3,
    S_GLOOP  = 26'd1 << 4,
    S_GINC   = 26'd1 << 5,
    S_SSTART = 26'd1 << 6,
    S_SCHK   = 26'd1 << 7,
    S_SPLIT  = 26'd1 << 8,
    S_ADONE  = 26'd1 << 9,
    S_RCHK   = 26'd1 << 10,
    S_RHDR   = 26'd1 << 11,
    S_MCHK   = 26'd1 << 12,
    S_MTST   = 26'd1 << 13,
    S_MPOST  = 26'd1 << 14,
    S_MSZ    = 26'd1 << 15,
    S_RDONE  = 26'd1 << 16,
    S_AP0    = 26'd1 << 17,
    S_AP1    = 26'd1 << 18,
    S_AP2    = 26'd1 << 19,
    S_AP3    = 26'd1 << 20,
    S_UL0    = 26'd1 << 21,
    S_UL1    = 26'd1 << 22,
    S_UL2    = 26'd1 << 23,
    S_UL3    = 26'd1 << 24,
    S_FIN    = 26'd1 << 25
  } seq_state_t;

  seq_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]        hs_r, hs_nxt;
  logic [CW-1:0]     head_r, head_nxt;
  logic [LOG_W-1:0]  root_r, root_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TOT_W-1:0]  reqtot_r, reqtot_nxt;
  logic [TOT_W-1:0]  blktot_r, blktot_nxt;
  logic [15:0]       req_r, req_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [31:0]       off_r, off_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic [CW-1:0]     sc_r, sc_nxt;
  logic [LOG_W-1:0]  s_r, s_nxt;
  logic [LOG_W-1:0]  r_r, r_nxt;
  logic [CW:0]       steps_r, steps_nxt;
  logic              pass_r, pass_nxt;
  logic [CW-1:0]     apc_r, apc_nxt;
  logic              apsz_r, apsz_nxt;
  logic [LOG_W-1:0]  apsv_r, apsv_nxt;
  logic [CW-1:0]     second_r, second_nxt;
  logic [CW-1:0]     ulc_r, ulc_nxt;
  logic [CW-1:0]     before_r, before_nxt;
  logic [CW-1:0]     after_r, after_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [31:0]       ptr_r, ptr_nxt;

  logic [NEED_W-1:0] need_in;
  logic [32:0]       pow_rd;
  logic [32:0]       pow_s;

  assign need_in = ((NEED_W'(request_bytes) + ROUND_ADD) & ~ROUND_ADD)
                   + NEED_W'(HDR_BYTES);
  assign pow_rd  = pow2(rd_size);
  assign pow_s   = pow2(s_r);

  // Control and statistics registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      hs_r     <= HS_UNINIT;
      head_r   <= '0;
      root_r   <= LOG_W'(ROOT_INIT);
      count_r  <= '0;
      reqtot_r <= '0;
      blktot_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      hs_r     <= hs_nxt;
      head_r   <= head_nxt;
      root_r   <= root_nxt;
      count_r  <= count_nxt;
      reqtot_r <= reqtot_nxt;
      blktot_r <= blktot_nxt;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    need_r   <= need_nxt;
    off_r    <= off_nxt;
    c_r      <= c_nxt;
    sc_r     <= sc_nxt;
    s_r      <= s_nxt;
    r_r      <= r_nxt;
    steps_r  <= steps_nxt;
    pass_r   <= pass_nxt;
    apc_r    <= apc_nxt;
    apsz_r   <= apsz_nxt;
    apsv_r   <= apsv_nxt;
    second_r <= second_nxt;
    ulc_r    <= ulc_nxt;
    before_r <= before_nxt;
    after_r  <= after_nxt;
    status_r <= status_nxt;
    ptr_r    <= ptr_nxt;
  end

  // Sequencer of allocate and release transactions over the header memory.
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    hs_nxt     = hs_r;
    head_nxt   = head_r;
    root_nxt   = root_r;
    count_nxt  = count_r;
    reqtot_nxt = reqtot_r;
    blktot_nxt = blktot_r;
    req_nxt    = req_r;
    need_nxt   = need_r;
    off_nxt    = off_r;
    c_nxt      = c_r;
    sc_nxt     = sc_r;
    s_nxt      = s_r;
    r_nxt      = r_r;
    steps_nxt  = steps_r;
    pass_nxt   = pass_r;
    apc_nxt    = apc_r;
    apsz_nxt   = apsz_r;
    apsv_nxt   = apsv_r;
    second_nxt = second_r;
    ulc_nxt    = ulc_r;
    before_nxt = before_r;
    after_nxt  = after_r;
    status_nxt = status_r;
    ptr_nxt    = ptr_r;
    mem_addr   = c_r;
    mem_we     = '0;
    w_size     = s_r;
    w_next     = '0;
    w_prev     = '0;
    w_free     = 1'b0;
    w_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = request_bytes;
          need_nxt   = need_in;
          ptr_nxt    = '0;
          status_nxt = ST_NOP;
          if (cmd == CMD_ALLOC) begin
            if (request_bytes == '0)   state_nxt = S_FIN;
            else if (hs_r == HS_UNINIT) state_nxt = S_INIT;
            else                        state_nxt = S_ACHK;
          end else begin
            off_nxt = release_pointer - heap_base - HDR_BYTES;
            if (release_pointer == '0 || hs_r == HS_UNINIT) state_nxt = S_FIN;
            else                                            state_nxt = S_RCHK;
          end
        end
      end

      // First allocate: the whole root becomes one free block.
      S_INIT: begin
        mem_addr  = '0;
        mem_we    = '{size: 1'b1, nxt: 1'b1, prv: 1'b1, free: 1'b1, req: 1'b0};
        w_size    = root_r;
        w_free    = 1'b1;
        hs_nxt    = HS_NORMAL;
        head_nxt  = '0;
        state_nxt = S_ACHK;
      end

      S_ACHK: begin
        pass_nxt = 1'b0;
        if (hs_r == HS_EMPTY) begin
          if (root_r >= HEAP_L) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            r_nxt     = root_r + LOG_W'(1);
            state_nxt = S_GLOOP;
          end
        end else begin
          state_nxt = S_SSTART;
        end
      end

      // Target root size for a request that found no block.
      S_GCALC: begin
        if (r_r >= HEAP_L) begin
          status_nxt = ST_FULL;
          state_nxt  = S_FIN;
        end else begin
          r_nxt = r_r + LOG_W'(1);
          if (pow2(r_r) >= 33'(need_r)) begin
            pass_nxt  = 1'b1;
            state_nxt = S_GLOOP;
          end
        end
      end

      // Each doubling adds the new upper half as a free block.
      S_GLOOP: begin
        if (root_r < r_r) begin
          apc_nxt   = cell_pow(root_r - MIN_L);
          apsz_nxt  = 1'b1;
          apsv_nxt  = root_r;
          ret_nxt   = S_GINC;
          state_nxt = S_AP0;
        end else begin
          state_nxt = S_SSTART;
        end
      end

      S_GINC: begin
        root_nxt  = root_r + LOG_W'(1);
        state_nxt = S_GLOOP;
      end

      S_SSTART: begin
        mem_addr  = head_r;
        c_nxt     = head_r;
        steps_nxt = '0;
        state_nxt = S_SCHK;
      end

      // Walk the free list; the next entry is read while this one is checked.
      S_SCHK: begin
        if (pow_rd >= 33'(need_r)) begin
          s_nxt     = rd_size;
          state_nxt = S_SPLIT;
        end else if (rd_next == head_r || steps_r == STEP_MAX) begin
          if (pass_r) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            r_nxt     = root_r;
            state_nxt = S_GCALC;
          end
        end else begin
          mem_addr  = rd_next;
          c_nxt     = rd_next;
          steps_nxt = steps_r + (CW+1)'(1);
        end
      end

      // Halve the block while half of it still holds the request.
      S_SPLIT: begin
        if (s_r > MIN_L && {14'b0, need_r, 1'b0} <= pow_s) begin
          s_nxt     = s_r - LOG_W'(1);
          mem_addr  = c_r;
          mem_we.size = 1'b1;
          w_size    = s_r - LOG_W'(1);
          apc_nxt   = c_r + cell_pow(s_r - LOG_W'(1) - MIN_L);
          apsz_nxt  = 1'b1;
          apsv_nxt  = s_r - LOG_W'(1);
          ret_nxt   = S_SPLIT;
          state_nxt = S_AP0;
        end else begin
          ulc_nxt   = c_r;
          ret_nxt   = S_ADONE;
          state_nxt = S_UL0;
        end
      end

      S_ADONE: begin
        mem_addr   = c_r;
        mem_we.req = 1'b1;
        w_req      = REQ_W'(req_r);
        reqtot_nxt = reqtot_r + TOT_W'(req_r);
        blktot_nxt = blktot_r + pow_s[TOT_W-1:0];
        count_nxt  = count_r + CNT_W'(1);
        ptr_nxt    = heap_base + (32'(c_r) << MIN_BLOCK_LOG) + HDR_BYTES;
        status_nxt = ST_DONE;
        state_nxt  = S_FIN;
      end

      // Release: offset checks, then the header read.
      S_RCHK: begin
        if (33'(off_r) >= pow2(root_r) || off_r[MIN_BLOCK_LOG-1:0] != '0) begin
          state_nxt = S_FIN;
        end else begin
          c_nxt     = off_r[MIN_BLOCK_LOG +: CW];
          mem_addr  = off_r[MIN_BLOCK_LOG +: CW];
          state_nxt = S_RHDR;
        end
      end

      S_RHDR: begin
        if (rd_free || rd_size < MIN_L || rd_size > root_r ||
            (33'(off_r) & (pow_rd - 33'(1))) != '0) begin
          state_nxt = S_FIN;
        end else begin
          reqtot_nxt = reqtot_r - rd_req;
          blktot_nxt = blktot_r - pow_rd[TOT_W-1:0];
          count_nxt  = count_r - CNT_W'(1);
          s_nxt      = rd_size;
          state_nxt  = S_MCHK;
        end
      end

      // Merge upward while the buddy is free and of equal size.
      S_MCHK: begin
        if (s_r < root_r) begin
          sc_nxt    = c_r ^ cell_pow(s_r - MIN_L);
          mem_addr  = c_r ^ cell_pow(s_r - MIN_L);
          state_nxt = S_MTST;
        end else begin
          apc_nxt   = c_r;
          apsz_nxt  = 1'b0;
          ret_nxt   = S_RDONE;
          state_nxt = S_AP0;
        end
      end

      S_MTST: begin
        if (!rd_free || rd_size != s_r) begin
          apc_nxt   = c_r;
          apsz_nxt  = 1'b0;
          ret_nxt   = S_RDONE;
          state_nxt = S_AP0;
        end else begin
          ulc_nxt   = sc_r;
          ret_nxt   = S_MPOST;
          state_nxt = S_UL0;
        end
      end

      // The absorbed header stays marked free.
      S_MPOST: begin
        mem_we.free = 1'b1;
        w_free      = 1'b1;
        if ((c_r & cell_pow(s_r - MIN_L)) == '0) begin
          mem_addr = sc_r;
        end else begin
          mem_addr = c_r;
          c_nxt    = sc_r;
        end
        state_nxt = S_MSZ;
      end

      S_MSZ: begin
        mem_addr    = c_r;
        mem_we.size = 1'b1;
        w_size      = s_r + LOG_W'(1);
        s_nxt       = s_r + LOG_W'(1);
        state_nxt   = S_MCHK;
      end

      S_RDONE: begin
        status_nxt = ST_DONE;
        state_nxt  = S_FIN;
      end

      // Append apc_r just after the list head, or make it the head of an empty list.
      S_AP0: begin
        if (hs_r == HS_EMPTY) begin
          mem_addr  = apc_r;
          mem_we    = '{size: apsz_r, nxt: 1'b1, prv: 1'b1, free: 1'b1, req: 1'b0};
          w_size    = apsv_r;
          w_next    = apc_r;
          w_prev    = apc_r;
          w_free    = 1'b1;
          head_nxt  = apc_r;
          hs_nxt    = HS_NORMAL;
          state_nxt = ret_r;
        end else begin
          mem_addr  = head_r;
          state_nxt = S_AP1;
        end
      end

      S_AP1: begin
        second_nxt = rd_next;
        mem_addr   = head_r;
        mem_we.nxt = 1'b1;
        w_next     = apc_r;
        state_nxt  = S_AP2;
      end

      S_AP2: begin
        mem_addr  = apc_r;
        mem_we    = '{size: apsz_r, nxt: 1'b1, prv: 1'b1, free: 1'b1, req: 1'b0};
        w_size    = apsv_r;
        w_next    = second_r;
        w_prev    = head_r;
        w_free    = 1'b1;
        state_nxt = S_AP3;
      end

      S_AP3: begin
        mem_addr   = second_r;
        mem_we.prv = 1'b1;
        w_prev     = apc_r;
        state_nxt  = ret_r;
      end

      // Unlink ulc_r from the list.
      S_UL0: begin
        mem_addr  = ulc_r;
        state_nxt = S_UL1;
      end

      S_UL1: begin
        before_nxt = rd_prev;
        after_nxt  = rd_next;
        mem_addr   = rd_prev;
        mem_we.nxt = 1'b1;
        w_next     = rd_next;
        if (head_r == ulc_r) begin
          head_nxt = rd_next;
          if (rd_next == ulc_r) hs_nxt = HS_EMPTY;
        end
        state_nxt = S_UL2;
      end

      S_UL2: begin
        mem_addr   = after_r;
        mem_we.prv = 1'b1;
        w_prev     = before_r;
        state_nxt  = S_UL3;
      end

      S_UL3: begin
        mem_addr    = ulc_r;
        mem_we.free = 1'b1;
        w_free      = 1'b0;
        state_nxt   = ret_r;
      end

      S_FIN: begin
        if (res_take) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res = '{status: status_r, ptr: ptr_r, root: root_r, count: count_r,
                 req_total: reqtot_r, blk_total: blktot_r};

endmodule
`default_nettype wire

FILE: hw/rtl/buddy_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Buddy allocator over a power-of-two heap at heap_base, one header entry per
// 2^MIN_BLOCK_LOG-byte cell in a single-port header memory. A zero request or
// null release finishes without a header access; an allocate walks the free
// list, splits the block that it finds and doubles the root where none fits,
// and a release merges buddies. Every access goes through the single header
// memory port, whose read is registered. One transaction is worked at a time;
// the finished result sits in an output register so the next request is taken
// while it waits. No clearing pass is needed after reset.
module buddy_heap_allocator
  import bha_pkg::*;
#(
  parameter int HEAP_LOG         = HEAP_LOG_DEF,
  parameter int MIN_BLOCK_LOG    = MIN_BLOCK_LOG_DEF,
  parameter int INITIAL_ROOT_LOG = INITIAL_ROOT_LOG_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bha_in_if.sink    in_ch,
  bha_out_if.source out_ch,
  bha_cfg_if.sink   cfg_ch
);

  localparam int CW = HEAP_LOG - MIN_BLOCK_LOG;

  logic [31:0]      heap_base_r;
  logic             seq_idle;
  logic             res_valid;
  logic             res_take;
  res_t             res;
  res_t             out_r;
  logic             out_valid_r;
  logic [CW-1:0]    mem_addr;
  mem_we_t          mem_we;
  logic [LOG_W-1:0] w_size, rd_size;
  logic [CW-1:0]    w_next, rd_next, w_prev, rd_prev;
  logic             w_free, rd_free;
  logic [REQ_W-1:0] w_req, rd_req;

  // Configuration register.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) heap_base_r <= '0;
    else if (cfg_ch.valid) heap_base_r <= cfg_ch.heap_base;
  end

  assign in_ch.ready = seq_idle;

  bha_seq #(
    .HEAP_LOG(HEAP_LOG), .MIN_BLOCK_LOG(MIN_BLOCK_LOG),
    .INITIAL_ROOT_LOG(INITIAL_ROOT_LOG), .CW(CW)
  ) u_seq (
    .clk, .rst_n,
    .start(in_ch.valid && seq_idle),
    .cmd(in_ch.cmd), .request_bytes(in_ch.request_bytes),
    .release_pointer(in_ch.release_pointer),
    .heap_base(heap_base_r),
    .idle(seq_idle), .res_valid, .res_take, .res,
    .mem_addr, .mem_we, .w_size, .w_next, .w_prev, .w_free, .w_req,
    .rd_size, .rd_next, .rd_prev, .rd_free, .rd_req
  );

  bha_cell_mem #(.CW(CW)) u_mem (
    .clk, .addr(mem_addr), .we(mem_we),
    .w_size, .w_next, .w_prev, .w_free, .w_req,
    .rd_size, .rd_next, .rd_prev, .rd_free, .rd_req
  );

  // Output register: a result moves in once the previous one has left.
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.status               = out_r.status;
  assign out_ch.payload_pointer      = out_r.ptr;
  assign out_ch.root_size_log        = out_r.root;
  assign out_ch.live_allocations     = out_r.count;
  assign out_ch.live_requested_bytes = out_r.req_total;
  assign out_ch.live_block_bytes     = out_r.blk_total;

endmodule
`default_nettype wire

FILE: hw/rtl/bha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bha_checker
  import bha_pkg::*;
#(
  parameter int HEAP_LOG      = HEAP_LOG_DEF,
  parameter int MIN_BLOCK_LOG = MIN_BLOCK_LOG_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] payload_pointer,
  input wire logic [4:0]  root_size_log
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // After a request is taken the block is busy with it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  // Only a successful allocate carries a pointer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_DONE |-> payload_pointer == '0)
    else $error("pointer given with a failed or empty transaction");

  // The managed root stays within the heap limits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> root_size_log >= 5'(MIN_BLOCK_LOG) && root_size_log <= 5'(HEAP_LOG))
    else $error("root size outside the heap limits");

endmodule

bind buddy_heap_allocator bha_checker #(
  .HEAP_LOG(HEAP_LOG), .MIN_BLOCK_LOG(MIN_BLOCK_LOG)
) u_bha_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .payload_pointer(out_ch.payload_pointer),
  .root_size_log(out_ch.root_size_log)
);
`default_nettype wire
